// ===== hw/rtl/msd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

  // fixed-point format
  localparam int FRAC = 16;

  // shared multiplier: A operand by B operand, B taken one digit per cycle
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 40;
  localparam int MUL_DIG   = 8;
  localparam int MUL_STEPS = MUL_B_W / MUL_DIG;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  // restoring divider
  localparam int DIV_N_W = 50;
  localparam int DIV_D_W = 34;

  // square root
  localparam int RAD_W  = 66;
  localparam int ROOT_W = RAD_W / 2;

  // internal magnitude clamp at 2^62-1
  localparam int MAG_W = 62;
  localparam logic [MAG_W-1:0] CAP = {MAG_W{1'b1}};

  localparam logic signed [63:0] F48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] F48_MIN = -64'sh0000_8000_0000_0000;

  localparam logic [16:0] ONE_FX = 17'h10000;

  // register indexes
  localparam logic [2:0] REG_DAMPING = 3'd0;
  localparam logic [2:0] REG_NATFREQ = 3'd1;
  localparam logic [2:0] REG_MASS    = 3'd2;
  localparam logic [2:0] REG_REST    = 3'd3;
  localparam logic [2:0] REG_CHAINS  = 3'd4;
  localparam logic [2:0] REG_RELAX   = 3'd5;

  typedef struct packed {
    logic signed [31:0] attach_x;
    logic signed [31:0] attach_y;
    logic signed [31:0] attach_z;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               slack;
    logic               saturated;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_RSQ, OP_SQ0, OP_SQ1, OP_SQ2, OP_SQRT,
    OP_DIV0, OP_DIV1, OP_DIV2, OP_DV0, OP_DV1, OP_DV2,
    OP_PW, OP_PWM, OP_CDIV, OP_WW, OP_WWM, OP_KDIV, OP_CV, OP_KE,
    OP_AD0, OP_AD1, OP_AD2, OP_RR0, OP_RR1, OP_RR2, OP_PR0, OP_PR1, OP_PR2
  } op_t;

  typedef enum logic [1:0] {
    UNIT_MUL, UNIT_DIV, UNIT_SQRT
  } unit_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_CHECK, ST_FINISH
  } st_t;

  typedef struct packed {
    logic load;
    logic start;
    logic clear;
    logic emit;
    op_t  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic taut;
    logic out_free;
  } ctrl_stat_t;

  function automatic op_t op_next(input op_t op);
    op_t n;
    case (op)
      OP_RSQ:  n = OP_SQ0;
      OP_SQ0:  n = OP_SQ1;
      OP_SQ1:  n = OP_SQ2;
      OP_SQ2:  n = OP_SQRT;
      OP_SQRT: n = OP_DIV0;
      OP_DIV0: n = OP_DIV1;
      OP_DIV1: n = OP_DIV2;
      OP_DIV2: n = OP_DV0;
      OP_DV0:  n = OP_DV1;
      OP_DV1:  n = OP_DV2;
      OP_DV2:  n = OP_PW;
      OP_PW:   n = OP_PWM;
      OP_PWM:  n = OP_CDIV;
      OP_CDIV: n = OP_WW;
      OP_WW:   n = OP_WWM;
      OP_WWM:  n = OP_KDIV;
      OP_KDIV: n = OP_CV;
      OP_CV:   n = OP_KE;
      OP_KE:   n = OP_AD0;
      OP_AD0:  n = OP_AD1;
      OP_AD1:  n = OP_AD2;
      OP_AD2:  n = OP_RR0;
      OP_RR0:  n = OP_RR1;
      OP_RR1:  n = OP_RR2;
      OP_RR2:  n = OP_PR0;
      OP_PR0:  n = OP_PR1;
      OP_PR1:  n = OP_PR2;
      default: n = OP_PR2;
    endcase
    return n;
  endfunction

  function automatic unit_t op_unit(input op_t op);
    unit_t u;
    case (op)
      OP_SQRT:                            u = UNIT_SQRT;
      OP_DIV0, OP_DIV1, OP_DIV2,
      OP_CDIV, OP_KDIV:                   u = UNIT_DIV;
      default:                            u = UNIT_MUL;
    endcase
    return u;
  endfunction

  function automatic logic [1:0] op_lane(input op_t op);
    logic [1:0] l;
    case (op)
      OP_SQ1, OP_DIV1, OP_DV1, OP_AD1, OP_RR1, OP_PR1: l = 2'd1;
      OP_SQ2, OP_DIV2, OP_DV2, OP_AD2, OP_RR2, OP_PR2: l = 2'd2;
      default:                                         l = 2'd0;
    endcase
    return l;
  endfunction

  // product shifted down by FRAC, magnitude clamped at CAP
  function automatic logic [MAG_W-1:0] shc(input logic [MUL_P_W-1:0] p);
    return (p[MUL_P_W-1:MAG_W+FRAC] != '0) ? CAP : p[MAG_W+FRAC-1:FRAC];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msd_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msd_mul
  import msd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [MUL_P_W-1:0]      prod
);

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_A_W+MUL_DIG-1:0] pp;

  // top digit of B first: shift the sum and add the next partial product
  assign pp = a_r * b_r[MUL_B_W-1 -: MUL_DIG];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      prod <= '0;
    end else if (busy) begin
      b_r  <= {b_r[MUL_B_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}};
      prod <= {prod[MUL_P_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}} + MUL_P_W'(pp);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msd_div
  import msd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] dividend,
  input  wire logic [DIV_D_W-1:0] divisor,
  output logic                    done,
  output logic [DIV_N_W-1:0]      quot
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  // quot shifts out dividend bits at the top and takes quotient bits in below
  assign rem_sh = {rem, quot[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= fits ? DIV_D_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_D_W-1:0];
      quot <= {quot[DIV_N_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msd_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msd_sqrt
  import msd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  rad_in,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int ITER  = ROOT_W;
  localparam int CNT_W = $clog2(ITER);
  localparam int REM_W = ROOT_W + 2;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // one root bit per cycle, two radicand bits per cycle
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msd_ctrl
  import msd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd
);

  st_t state, state_next;
  op_t op, op_nx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_RSQ;
    end else begin
      state <= state_next;
      op    <= op_nx;
    end
  end

  always_comb begin
    state_next = state;
    op_nx      = op;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ISSUE;
          op_nx      = OP_RSQ;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (stat.done) begin
          if (op == OP_SQ2) begin
            state_next = ST_CHECK;
          end else if (op == OP_PR2) begin
            state_next = ST_FINISH;
          end else begin
            op_nx      = op_next(op);
            state_next = ST_ISSUE;
          end
        end
      end
      ST_CHECK: begin
        if (stat.taut) begin
          op_nx      = OP_SQRT;
          state_next = ST_ISSUE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.start = 1'b0;
    cmd.clear = 1'b0;
    cmd.emit  = 1'b0;
    cmd.op    = op;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_ISSUE:  cmd.start = 1'b1;
      ST_WAIT:   ;
      ST_CHECK:  cmd.clear = !stat.taut;
      ST_FINISH: cmd.emit  = stat.out_free;
      default:   ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msd_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msd_dpath
  import msd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ctrl_cmd_t  cmd,
  output ctrl_stat_t      stat,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration
  logic [23:0] damp, wn;
  logic [31:0] mass;
  logic [30:0] rest;
  logic [7:0]  chains;
  logic [16:0] relax;

  // item working set
  logic [32:0]        rmag [3];
  logic               rneg [3];
  logic [31:0]        vmag [3];
  logic               vneg [3];
  logic [16:0]        dmag [3];
  logic               dneg [3];
  logic [MAG_W-1:0]   rawmag [3];
  logic               rawneg [3];
  logic signed [63:0] s [3];
  logic signed [47:0] prev [3];
  logic signed [47:0] f [3];
  logic [RAD_W-1:0]   ssum;
  logic [61:0]        r2;
  logic [ROOT_W-1:0]  len;
  logic signed [50:0] acc;
  logic [MAG_W-1:0]   t1, t2;
  logic [48:0]        c;
  logic [47:0]        k;
  logic signed [63:0] sa;
  logic [MAG_W-1:0]   amag;
  logic               aneg;
  logic               slack_f, sat_f;

  // unit ports
  logic               mul_start, div_start, sqrt_start;
  logic               mul_done, div_done, sqrt_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mprod;
  logic [DIV_N_W-1:0] div_n, quot;
  logic [DIV_D_W-1:0] div_d;
  logic [ROOT_W-1:0]  root;

  // derived values
  logic [1:0]         ln;
  unit_t              unit;
  logic [16:0]        relax_c, one_minus;
  logic [7:0]         chains_c;
  logic [50:0]        acc_abs;
  logic [34:0]        vrmag;
  logic [ROOT_W-1:0]  ext;
  logic [47:0]        pmag;
  logic [MAG_W-1:0]   shv;
  logic signed [63:0] shs;
  logic signed [63:0] ke_sum;
  logic [63:0]        ke_abs;
  logic signed [63:0] pr_sum;

  assign ln        = op_lane(cmd.op);
  assign unit      = op_unit(cmd.op);
  assign relax_c   = (relax > ONE_FX) ? ONE_FX : relax;
  assign one_minus = ONE_FX - relax_c;
  assign chains_c  = (chains == 8'd0) ? 8'd1 : chains;
  assign acc_abs   = acc[50] ? 51'(-acc) : 51'(acc);
  assign vrmag     = acc_abs[50:FRAC];
  assign ext       = len - ROOT_W'(rest);
  assign pmag      = prev[ln][47] ? 48'(-prev[ln]) : 48'(prev[ln]);
  assign shv       = shc(mprod);
  assign shs       = $signed({2'b00, shv});
  assign ke_sum    = sa + shs;
  assign ke_abs    = ke_sum[63] ? 64'(-ke_sum) : 64'(ke_sum);
  assign pr_sum    = s[ln] + (prev[ln][47] ? -shs : shs);

  assign mul_start  = cmd.start && (unit == UNIT_MUL);
  assign div_start  = cmd.start && (unit == UNIT_DIV);
  assign sqrt_start = cmd.start && (unit == UNIT_SQRT);

  always_comb begin
    unique case (unit)
      UNIT_DIV:  stat.done = div_done;
      UNIT_SQRT: stat.done = sqrt_done;
      default:   stat.done = mul_done;
    endcase
    stat.taut     = ssum > {4'b0000, r2};
    stat.out_free = !out_valid || out_ready;
  end

  // multiplier operands: wider operand on A
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_RSQ: begin
        mul_a = MUL_A_W'(rest);
        mul_b = MUL_B_W'(rest);
      end
      OP_SQ0, OP_SQ1, OP_SQ2: begin
        mul_a = MUL_A_W'(rmag[ln]);
        mul_b = MUL_B_W'(rmag[ln]);
      end
      OP_DV0, OP_DV1, OP_DV2: begin
        mul_a = MUL_A_W'(vmag[ln]);
        mul_b = MUL_B_W'(dmag[ln]);
      end
      OP_PW: begin
        mul_a = MUL_A_W'(damp);
        mul_b = MUL_B_W'(wn);
      end
      OP_PWM: begin
        mul_a = MUL_A_W'(mass);
        mul_b = MUL_B_W'(t1[31:0]);
      end
      OP_WW: begin
        mul_a = MUL_A_W'(wn);
        mul_b = MUL_B_W'(wn);
      end
      OP_WWM: begin
        mul_a = MUL_A_W'(mass);
        mul_b = MUL_B_W'(t2[31:0]);
      end
      OP_CV: begin
        mul_a = MUL_A_W'(c);
        mul_b = MUL_B_W'(vrmag);
      end
      OP_KE: begin
        mul_a = MUL_A_W'(k);
        mul_b = MUL_B_W'(ext);
      end
      OP_AD0, OP_AD1, OP_AD2: begin
        mul_a = MUL_A_W'(amag);
        mul_b = MUL_B_W'(dmag[ln]);
      end
      OP_RR0, OP_RR1, OP_RR2: begin
        mul_a = MUL_A_W'(rawmag[ln]);
        mul_b = MUL_B_W'(relax_c);
      end
      OP_PR0, OP_PR1, OP_PR2: begin
        mul_a = MUL_A_W'(pmag);
        mul_b = MUL_B_W'(one_minus);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_n = '0;
    div_d = '0;
    case (cmd.op)
      OP_DIV0, OP_DIV1, OP_DIV2: begin
        div_n = DIV_N_W'({rmag[ln], {FRAC{1'b0}}});
        div_d = DIV_D_W'(len);
      end
      OP_CDIV: begin
        div_n = DIV_N_W'({t1[47:0], 1'b0});
        div_d = DIV_D_W'(chains_c);
      end
      OP_KDIV: begin
        div_n = DIV_N_W'(t2[47:0]);
        div_d = DIV_D_W'(chains_c);
      end
      default: ;
    endcase
  end

  msd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mprod)
  );

  msd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (quot)
  );

  msd_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (sqrt_start),
    .rad_in (ssum),
    .done   (sqrt_done),
    .root   (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      damp   <= 24'h01_0000;
      wn     <= '0;
      mass   <= '0;
      rest   <= '0;
      chains <= 8'd1;
      relax  <= 17'd52429;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DAMPING: damp   <= cfg_data[23:0];
        REG_NATFREQ: wn     <= cfg_data[23:0];
        REG_MASS:    mass   <= cfg_data;
        REG_REST:    rest   <= cfg_data[30:0];
        REG_CHAINS:  chains <= cfg_data[7:0];
        REG_RELAX:   relax  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // prev holds state across items and is cleared by reset and by clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) prev[i] <= '0;
    end else if (cmd.clear) begin
      for (int i = 0; i < 3; i++) prev[i] <= '0;
    end else if (mul_done && (cmd.op == OP_PR0 || cmd.op == OP_PR1 || cmd.op == OP_PR2)) begin
      if (pr_sum > F48_MAX)      prev[ln] <= F48_MAX[47:0];
      else if (pr_sum < F48_MIN) prev[ln] <= F48_MIN[47:0];
      else                       prev[ln] <= pr_sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin : capture
      logic signed [32:0] r0, r1, r2v;
      r0  = {in_data.attach_x[31], in_data.attach_x} - {in_data.anchor_x[31], in_data.anchor_x};
      r1  = {in_data.attach_y[31], in_data.attach_y} - {in_data.anchor_y[31], in_data.anchor_y};
      r2v = {in_data.attach_z[31], in_data.attach_z} - {in_data.anchor_z[31], in_data.anchor_z};
      rmag[0] <= r0[32] ? 33'(-r0) : 33'(r0);
      rmag[1] <= r1[32] ? 33'(-r1) : 33'(r1);
      rmag[2] <= r2v[32] ? 33'(-r2v) : 33'(r2v);
      rneg[0] <= r0[32];
      rneg[1] <= r1[32];
      rneg[2] <= r2v[32];
      vmag[0] <= in_data.vel_x[31] ? 32'(-in_data.vel_x) : 32'(in_data.vel_x);
      vmag[1] <= in_data.vel_y[31] ? 32'(-in_data.vel_y) : 32'(in_data.vel_y);
      vmag[2] <= in_data.vel_z[31] ? 32'(-in_data.vel_z) : 32'(in_data.vel_z);
      vneg[0] <= in_data.vel_x[31];
      vneg[1] <= in_data.vel_y[31];
      vneg[2] <= in_data.vel_z[31];
      ssum    <= '0;
      acc     <= '0;
      sat_f   <= 1'b0;
      slack_f <= 1'b0;
    end
    if (cmd.clear) begin
      for (int i = 0; i < 3; i++) f[i] <= '0;
      slack_f <= 1'b1;
      sat_f   <= 1'b0;
    end
    if (sqrt_done) len <= root;
    if (div_done) begin
      case (cmd.op)
        OP_DIV0, OP_DIV1, OP_DIV2: begin
          dmag[ln] <= quot[16:0];
          dneg[ln] <= rneg[ln];
        end
        OP_CDIV: c <= quot[48:0];
        OP_KDIV: k <= quot[47:0];
        default: ;
      endcase
    end
    if (mul_done) begin
      case (cmd.op)
        OP_RSQ:                 r2   <= mprod[61:0];
        OP_SQ0, OP_SQ1, OP_SQ2: ssum <= ssum + mprod[RAD_W-1:0];
        OP_DV0, OP_DV1, OP_DV2: begin
          if (vneg[ln] ^ dneg[ln]) acc <= acc - $signed({1'b0, mprod[49:0]});
          else                     acc <= acc + $signed({1'b0, mprod[49:0]});
        end
        OP_PW, OP_PWM:          t1 <= shv;
        OP_WW, OP_WWM:          t2 <= shv;
        OP_CV:                  sa <= acc[50] ? -shs : shs;
        OP_KE: begin
          aneg <= ke_sum[63];
          amag <= (ke_abs[63:MAG_W] != '0) ? CAP : ke_abs[MAG_W-1:0];
        end
        OP_AD0, OP_AD1, OP_AD2: begin
          rawmag[ln] <= shv;
          rawneg[ln] <= !aneg ^ dneg[ln];
        end
        OP_RR0, OP_RR1, OP_RR2: s[ln] <= rawneg[ln] ? -shs : shs;
        OP_PR0, OP_PR1, OP_PR2: begin
          if (pr_sum > F48_MAX) begin
            f[ln] <= F48_MAX[47:0];
            sat_f <= 1'b1;
          end else if (pr_sum < F48_MIN) begin
            f[ln] <= F48_MIN[47:0];
            sat_f <= 1'b1;
          end else begin
            f[ln] <= pr_sum[47:0];
          end
        end
        default: ;
      endcase
    end
  end

  // result register: freed when taken, refilled on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.force_x   <= f[0];
      out_data.force_y   <= f[1];
      out_data.force_z   <= f[2];
      out_data.slack     <= slack_f;
      out_data.saturated <= sat_f;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mooring_spring_damper_force.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_data   (in_item_t)
// out       output     out_valid / out_ready out_data  (out_item_t)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item at a time. A taut line runs five divisions on the one-bit-per-cycle
// divider, 22 products on the shared multiplier that takes eight B bits per
// cycle, and a square root, besides the handshake and checks. A slack line
// ends at the length check. Reset (rst, synchronous) restores the register
// defaults and clears the stored force; in and cfg are not ready during reset.
// A result waiting on out does not block the next item; that item's result
// then holds in the block until out frees.

module mooring_spring_damper_force
  import msd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // registers take a write in any cycle out of reset
  assign cfg_ready = !rst;

  // sequence the operations on the shared units
  msd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold operands and results, drive the units and the result register
  msd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire
